### rtl/bmns_pkg.sv
// Shared constants, types and register codes for the binary map smoothing block.
package bmns_pkg;

	// Map size limits and field widths
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 10;
	localparam int SIZE_W     = 11;
	localparam int THR_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int MIN_SIZE   = 3;
	localparam int WIN_CELLS  = 9;
	localparam int CNT_W      = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_MIN_COUNT = 2'd2;

	// Reset values of the registers
	localparam logic [SIZE_W-1:0] MAP_WIDTH_RST  = 11'd64;
	localparam logic [SIZE_W-1:0] MAP_HEIGHT_RST = 11'd64;
	localparam logic [THR_W-1:0]  WALL_MIN_RST   = 4'd4;

	// Line store entry: bit 0 row r-2, bit 1 row r-1
	localparam int LINE_W = 2;

	// Cell codes
	localparam logic CELL_WALL  = 1'b0;
	localparam logic CELL_SPACE = 1'b1;

	// Position of the cell offered at the input, after size wrapping
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             emit;      // row and column both nonzero
		logic             interior;  // row and column both at least 2
		logic             last;      // last cell of the map
	} pos_t;

	// Line store write port driven by the window stage
	typedef struct packed {
		logic              we;
		logic [COL_W-1:0]  addr;
		logic [LINE_W-1:0] data;
	} line_wr_t;

endpackage

### rtl/bmns_line_ram.sv
// Generic synchronous RAM with one write port and one registered read port.
module bmns_line_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/bmns_scan.sv
// Configuration registers and raster position counters.
module bmns_scan import bmns_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  take,
	output pos_t                  pos,
	output logic [THR_W-1:0]      wall_min
);

	logic [SIZE_W-1:0] map_width_q;
	logic [SIZE_W-1:0] map_height_q;
	logic [THR_W-1:0]  wall_min_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;

	logic [SIZE_W-1:0] w_eff;
	logic [SIZE_W-1:0] h_eff;
	logic              col_wrap;
	logic [SIZE_W-1:0] row_pre;
	logic [ROW_W-1:0]  r0;
	logic [COL_W-1:0]  c0;
	logic [SIZE_W-1:0] col_nx;
	logic [SIZE_W-1:0] row_nx;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_WIDTH_RST;
			map_height_q <= MAP_HEIGHT_RST;
			wall_min_q   <= WALL_MIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_WIDTH:      map_width_q  <= cfg_data;
				REG_MAP_HEIGHT:     map_height_q <= cfg_data;
				REG_WALL_MIN_COUNT: wall_min_q   <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp sizes into the supported range
	always_comb begin
		if (map_width_q < SIZE_W'(MIN_SIZE))
			w_eff = SIZE_W'(MIN_SIZE);
		else if (map_width_q > SIZE_W'(MAX_WIDTH))
			w_eff = SIZE_W'(MAX_WIDTH);
		else
			w_eff = map_width_q;
		if (map_height_q < SIZE_W'(MIN_SIZE))
			h_eff = SIZE_W'(MIN_SIZE);
		else if (map_height_q > SIZE_W'(MAX_HEIGHT))
			h_eff = SIZE_W'(MAX_HEIGHT);
		else
			h_eff = map_height_q;
	end

	// Wrap the stored position against the current size
	always_comb begin
		col_wrap = {1'b0, col_q} >= w_eff;
		c0       = col_wrap ? '0 : col_q;
		row_pre  = col_wrap ? ({1'b0, row_q} + SIZE_W'(1)) : {1'b0, row_q};
		r0       = (row_pre >= h_eff) ? '0 : row_pre[ROW_W-1:0];
	end

	// Position of the offered cell
	always_comb begin
		pos.row      = r0;
		pos.col      = c0;
		pos.emit     = (r0 != '0) && (c0 != '0);
		pos.interior = (r0[ROW_W-1:1] != '0) && (c0[COL_W-1:1] != '0);
		pos.last     = ({1'b0, r0} == h_eff - SIZE_W'(1)) &&
		               ({1'b0, c0} == w_eff - SIZE_W'(1));
		col_nx       = {1'b0, c0} + SIZE_W'(1);
		row_nx       = {1'b0, r0} + SIZE_W'(1);
	end

	// Advance on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (take) begin
			if (col_nx >= w_eff) begin
				col_q <= '0;
				row_q <= (row_nx >= h_eff) ? '0 : row_nx[ROW_W-1:0];
			end else begin
				col_q <= col_nx[COL_W-1:0];
				row_q <= r0;
			end
		end
	end

	assign wall_min = wall_min_q;

endmodule

### rtl/bmns_window.sv
// Window stage: builds the 3x3 window, counts walls, updates the line store, holds the result.
module bmns_window import bmns_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              cell_in,
	input  pos_t              pos,
	input  logic [LINE_W-1:0] line_rd,
	input  logic [THR_W-1:0]  wall_min,
	output line_wr_t          line_wr,
	output logic              can_take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_space,
	output logic [ROW_W-1:0]  out_r,
	output logic [COL_W-1:0]  out_c,
	output logic              out_last
);

	logic        v_s1;
	logic        cell_s1;
	pos_t        pos_s1;
	logic [5:0]  win_q;
	logic        adv_s1;
	logic [2:0]  column;
	logic [8:0]  window;
	logic [CNT_W-1:0] spaces;
	logic [CNT_W-1:0] walls;
	logic        result;

	// Stage 1 holds one cell while its line store data arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cell_s1 <= cell_in;
			pos_s1  <= pos;
		end
	end

	// Stage 1 leaves unless its result must wait on a full output register
	assign adv_s1   = v_s1 && (!pos_s1.emit || !out_valid || out_ready);
	assign can_take = !v_s1 || adv_s1;

	// Window column and wall count
	always_comb begin
		column = {cell_s1, line_rd[1], line_rd[0]};
		window = {win_q, column};
		spaces = '0;
		for (int i = 0; i < WIN_CELLS; i++) begin
			spaces = spaces + CNT_W'(window[i]);
		end
		walls = CNT_W'(WIN_CELLS) - spaces;
		if (!pos_s1.interior)
			result = CELL_WALL;
		else
			result = (walls >= wall_min) ? CELL_WALL : CELL_SPACE;
	end

	// Line store write back: row r-1 moves up, current row moves in
	always_comb begin
		line_wr.we   = adv_s1;
		line_wr.addr = pos_s1.col;
		line_wr.data = {cell_s1, line_rd[1]};
	end

	// Previous two window columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (adv_s1) begin
			win_q <= {win_q[2:0], column};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1 && pos_s1.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pos_s1.emit) begin
			out_space <= result;
			out_r     <= pos_s1.row - ROW_W'(1);
			out_c     <= pos_s1.col - COL_W'(1);
			out_last  <= pos_s1.last;
		end
	end

endmodule

### rtl/binary_map_neighbour_smoothing.sv
// Top level of the binary map 3x3 neighbour smoothing block.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------------
//  input    | in_valid / in_ready     | cell_is_space
//  output   | out_valid / out_ready   | smoothed_is_space, out_row, out_col, frame_done
//  config   | cfg_we (no wait)        | cfg_index, cfg_data
//
// One cell per clock sustained while the output does not stall; a result passes stage 1 into the output register.
// The line store RAM is read at acceptance and written back as stage 1 moves on, one port each.
// Reset clears positions and window columns and loads the register defaults; line store content is undefined.
// A stalled output register holds stage 1, which in turn holds off the input.
module binary_map_neighbour_smoothing import bmns_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cell_is_space,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  smoothed_is_space,
	output logic [ROW_W-1:0]      out_row,
	output logic [COL_W-1:0]      out_col,
	output logic                  frame_done
);

	pos_t              pos;
	logic [THR_W-1:0]  wall_min;
	logic              take;
	logic              can_take;
	line_wr_t          line_wr;
	logic [LINE_W-1:0] line_rd;

	assign in_ready = can_take;
	assign take     = in_valid && can_take;

	// Position counters and registers
	bmns_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.pos       (pos),
		.wall_min  (wall_min)
	);

	// Two rows above the current one, packed per column
	bmns_line_ram #(
		.DEPTH (MAX_WIDTH),
		.WIDTH (LINE_W)
	) u_line_ram (
		.clk   (clk),
		.we    (line_wr.we),
		.waddr (line_wr.addr),
		.wdata (line_wr.data),
		.re    (take),
		.raddr (pos.col),
		.rdata (line_rd)
	);

	// Window count and output register
	bmns_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.cell_in   (cell_is_space),
		.pos       (pos),
		.line_rd   (line_rd),
		.wall_min  (wall_min),
		.line_wr   (line_wr),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_space (smoothed_is_space),
		.out_r     (out_row),
		.out_c     (out_col),
		.out_last  (frame_done)
	);

	// Read and write back never hit the same line store entry in one cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		take && line_wr.we |-> pos.col != line_wr.addr)
		else $error("line store read and write to the same entry");

	// Border cells always come out as walls
	a_border_wall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && smoothed_is_space |-> out_row != '0 && out_col != '0)
		else $error("border cell emitted as space");

	// An accepted cell leaves stage 1 on the next edge unless the output stalls
	a_write_follows_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> line_wr.we || !out_ready || out_valid)
		else $error("accepted cell stuck in stage 1 without output back pressure");

	// Frame end lands on a nonzero column unless it is on row 0
	a_frame_done_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> out_col != '0 || out_row == '0)
		else $error("frame end on an unexpected cell");

endmodule

### verif/binary_map_neighbour_smoothing_tb.sv
// Self-checking testbench for the binary map 3x3 neighbour smoothing block.
module binary_map_neighbour_smoothing_tb import bmns_pkg::*; ();

	localparam int DRAIN_CYCLES = 4;
	localparam int QUIET_LIMIT  = 4000;
	localparam int PHASES       = 16;
	localparam int WIDE_PHASE   = 0;
	localparam int TALL_PHASE   = 1;
	localparam int HOLD_PHASE   = 4;
	localparam int SHORT_RUN    = 60;

	// One smoothed cell as the block reports it
	typedef struct packed {
		logic             space;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             done;
	} smooth_cell_t;

	typedef enum logic {PLAN_CFG, PLAN_CELL} plan_kind_t;

	typedef struct packed {
		plan_kind_t            kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  cell_val;
		logic                  pinned;
		smooth_cell_t          want;
	} plan_row_t;

	localparam smooth_cell_t NO_PIN = '0;

	// Smoke plan: 3x3 maps, fixed results typed in where they are obvious
	localparam plan_row_t SMOKE_PLAN [27] = '{
		// width 0 and height 2 both clamp up to 3
		'{PLAN_CFG,  REG_MAP_WIDTH,      11'd0, CELL_WALL,  1'b0, NO_PIN},
		'{PLAN_CFG,  REG_MAP_HEIGHT,     11'd2, CELL_WALL,  1'b0, NO_PIN},
		'{PLAN_CFG,  REG_WALL_MIN_COUNT, 11'd4, CELL_WALL,  1'b0, NO_PIN},
		// all spaces, threshold 4: borders are walls, center stays space, frame ends
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b1, '{CELL_WALL, 10'd0, 10'd0, 1'b0}},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b1, '{CELL_WALL, 10'd0, 10'd1, 1'b0}},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b1, '{CELL_WALL, 10'd1, 10'd0, 1'b0}},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b1, '{CELL_SPACE, 10'd1, 10'd1, 1'b1}},
		// threshold 0: every interior cell turns into a wall
		'{PLAN_CFG,  REG_WALL_MIN_COUNT, 11'd0, CELL_WALL,  1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b1, '{CELL_WALL, 10'd0, 10'd0, 1'b0}},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b1, '{CELL_WALL, 10'd0, 10'd1, 1'b0}},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b1, '{CELL_WALL, 10'd1, 10'd0, 1'b0}},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b1, '{CELL_WALL, 10'd1, 10'd1, 1'b1}},
		// mixed start of the next map, left to the predictor
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_WALL,  1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_WALL,  1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_SPACE, 1'b0, NO_PIN},
		'{PLAN_CELL, REG_MAP_WIDTH, 11'd0, CELL_WALL,  1'b0, NO_PIN}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  cell_is_space;
	logic                  out_valid;
	logic                  out_ready;
	logic                  smoothed_is_space;
	logic [ROW_W-1:0]      out_row;
	logic [COL_W-1:0]      out_col;
	logic                  frame_done;

	// Typed result travelling with the input payload
	logic                  cell_pinned;
	smooth_cell_t          pinned_cell;

	// Smoothing predictor state and its copy of the registers
	logic               line_upper [MAX_WIDTH] = '{default: 1'b0};
	logic               line_lower [MAX_WIDTH] = '{default: 1'b0};
	logic [1:0]         col_writes [MAX_WIDTH] = '{default: 2'd0};
	logic [5:0]         win_cols = '0;
	int unsigned        row_pos = 0;
	int unsigned        col_pos = 0;
	logic [SIZE_W-1:0]  map_cols = MAP_WIDTH_RST;
	logic [SIZE_W-1:0]  map_rows = MAP_HEIGHT_RST;
	logic [THR_W-1:0]   wall_min = WALL_MIN_RST;

	smooth_cell_t       smoothed_due [$];
	int unsigned        mismatches = 0;
	int unsigned        quiet_cycles = 0;
	int unsigned        send_idle_pct = 34;
	int unsigned        recv_idle_pct = 65;
	int unsigned        hold_request = 0;

	wire in_taken  = arst_n && in_valid && in_ready;
	wire out_taken = arst_n && out_valid && out_ready;

	binary_map_neighbour_smoothing DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cell_is_space    (cell_is_space),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.smoothed_is_space(smoothed_is_space),
		.out_row          (out_row),
		.out_col          (out_col),
		.frame_done       (frame_done)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] v, input int unsigned maxv);
		if (v < MIN_SIZE)
			return MIN_SIZE;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// Column past the width moves to the next row; row past the height restarts the map
	function automatic void wrap_to_map(input int unsigned w, input int unsigned h,
			inout int unsigned r, inout int unsigned c);
		if (c >= w) begin
			c = 0;
			r++;
		end
		if (r >= h)
			r = 0;
	endfunction

	// Advance the smoothing predictor by one cell; queue the cell it emits, if any
	function automatic void predict_smoothing(input logic cur, input logic pinned,
			input smooth_cell_t pin);
		int unsigned w, h, r, c, walls;
		logic [2:0] column;
		smooth_cell_t res;
		w = clamp_dim(map_cols, MAX_WIDTH);
		h = clamp_dim(map_rows, MAX_HEIGHT);
		r = row_pos;
		c = col_pos;
		wrap_to_map(w, h, r, c);
		column = {cur, line_lower[c], line_upper[c]};
		line_upper[c] = line_lower[c];
		line_lower[c] = cur;
		if (col_writes[c] != 2'd2)
			col_writes[c]++;
		if (r >= 1 && c >= 1) begin
			res.space = CELL_WALL;
			if (r >= 2 && c >= 2) begin
				walls = WIN_CELLS - $countones({win_cols, column});
				res.space = (walls >= wall_min) ? CELL_WALL : CELL_SPACE;
			end
			res.row  = ROW_W'(r - 1);
			res.col  = COL_W'(c - 1);
			res.done = (r == h - 1) && (c == w - 1);
			smoothed_due.push_back(pinned ? pin : res);
		end
		win_cols = {win_cols[2:0], column};
		c++;
		wrap_to_map(w, h, r, c);
		row_pos = r;
		col_pos = c;
	endfunction

	// Growing the width mid-map must not expose line store entries never written
	function automatic bit width_change_safe(input logic [SIZE_W-1:0] cols);
		int unsigned w, h, r, c;
		w = clamp_dim(cols, MAX_WIDTH);
		h = clamp_dim(map_rows, MAX_HEIGHT);
		r = row_pos;
		c = col_pos;
		wrap_to_map(w, h, r, c);
		if (r == 0 && c == 0)
			return 1'b1;
		for (int i = 0; i < w; i++)
			if (col_writes[i] != 2'd2)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic int unsigned cells_to_frame_end();
		int unsigned w, h, r, c;
		w = clamp_dim(map_cols, MAX_WIDTH);
		h = clamp_dim(map_rows, MAX_HEIGHT);
		r = row_pos;
		c = col_pos;
		wrap_to_map(w, h, r, c);
		return (h - r) * w - c;
	endfunction

	function automatic logic [SIZE_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return SIZE_W'($urandom_range(0, 2));
			1: return SIZE_W'($urandom_range(11, 24));
			default: return SIZE_W'($urandom_range(3, 10));
		endcase
	endfunction

	function automatic void check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Offer one cell and hold it until the transaction completes
	task automatic send_cell(input logic cell_val, input logic pinned, input smooth_cell_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		cell_is_space <= cell_val;
		cell_pinned   <= pinned;
		pinned_cell   <= want;
		do @(posedge clk); while (!in_taken);
	endtask

	task automatic run_phase(input int unsigned n_cells, input int unsigned space_pct);
		for (int i = 0; i < n_cells; i++)
			send_cell($urandom_range(99) < space_pct, 1'b0, NO_PIN);
	endtask

	// Stop offering, let every result drain and the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (smoothed_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MAP_WIDTH:      map_cols = val;
			REG_MAP_HEIGHT:     map_rows = val;
			REG_WALL_MIN_COUNT: wall_min = val[THR_W-1:0];
			default: ;
		endcase
	endtask

	// New map size and threshold, the old width kept when the new one is unsafe; unused upper threshold bits carry noise
	task automatic retarget(input logic [SIZE_W-1:0] cols, input logic [SIZE_W-1:0] rows,
			input logic [THR_W-1:0] thr);
		write_reg(REG_MAP_HEIGHT, rows);
		if (!width_change_safe(cols))
			cols = map_cols;
		write_reg(REG_MAP_WIDTH, cols);
		write_reg(REG_WALL_MIN_COUNT, {(CFG_DATA_W - THR_W)'($urandom_range(0, 127)), thr});
	endtask

	// Result checking, prediction at input transactions, and the watchdog
	always @(posedge clk) begin : check_results
		smooth_cell_t want;
		if (out_taken) begin
			if (smoothed_due.size() == 0) begin
				$display("%0t: result with nothing expected, row %0d col %0d", $time,
					out_row, out_col);
				mismatches++;
			end else begin
				want = smoothed_due.pop_front();
				check_field("smoothed_is_space", want.space, smoothed_is_space);
				check_field("out_row", want.row, out_row);
				check_field("out_col", want.col, out_col);
				check_field("frame_done", want.done, frame_done);
			end
		end
		if (in_taken)
			predict_smoothing(cell_is_space, cell_pinned, pinned_cell);
		if (in_taken || out_taken || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: random back-pressure plus one long hold-off
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Stimulus
	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_MAP_WIDTH;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		cell_is_space <= CELL_WALL;
		cell_pinned   <= 1'b0;
		pinned_cell   <= NO_PIN;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (SMOKE_PLAN[i]) begin
			if (SMOKE_PLAN[i].kind == PLAN_CFG) begin
				settle();
				write_reg(SMOKE_PLAN[i].reg_idx, SMOKE_PLAN[i].reg_val);
			end else begin
				send_cell(SMOKE_PLAN[i].cell_val, SMOKE_PLAN[i].pinned, SMOKE_PLAN[i].want);
			end
		end

		// Random maps; phases end mid-map, so size changes often land mid-frame
		for (int p = 0; p < PHASES; p++) begin
			if (p < 5) begin
				send_idle_pct = 34;
				recv_idle_pct = 65;
			end else if (p < 10) begin
				send_idle_pct = 65;
				recv_idle_pct = 34;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			settle();
			if (p == WIDE_PHASE) begin
				// finish the current map, then part of the first row of the widest map
				run_phase(cells_to_frame_end(), 50);
				settle();
				retarget(11'h7FF, 11'd3, THR_W'($urandom_range(0, 15)));
				run_phase(SHORT_RUN, 45);
			end else if (p == TALL_PHASE) begin
				// width drops below the wide row, so the map goes on at row 1 column 0;
				// row 1 windows are all border, later rows only see entries just written
				write_reg(REG_MAP_HEIGHT, 11'h7FF);
				write_reg(REG_MAP_WIDTH, 11'd24);
				write_reg(REG_WALL_MIN_COUNT, CFG_DATA_W'($urandom_range(0, 15)));
				run_phase(SHORT_RUN, 55);
			end else begin
				retarget(pick_dim(), pick_dim(),
					(p == 2) ? THR_W'(15) : (p == 3) ? THR_W'(9) : THR_W'($urandom_range(0, 15)));
				if (p == HOLD_PHASE)
					hold_request = 400;
				run_phase($urandom_range(18, 40), $urandom_range(10, 90));
			end
		end

		settle();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
